FILE: hdl/utf8ct_pkg.sv
`timescale 1ns / 1ps

package utf8ct_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] LEAD_D0_BYTE = 8'hD0;
    localparam logic [7:0] LEAD_D1_BYTE = 8'hD1;
    localparam logic [7:0] NO_MAP_CHAR  = 8'h3F;
    localparam logic [7:0] NUL_CHAR     = 8'h00;

    // One queued run: 1..3 characters, c0 goes out first.
    typedef struct packed {
        logic [1:0] len;
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t data;
    } push_t;

    typedef struct packed {
        logic   avail;
        entry_t head;
    } head_t;

    function automatic entry_t mk(input logic [1:0] n, input logic [7:0] a,
                                  input logic [7:0] b, input logic [7:0] c);
        entry_t e;
        e.len = n;
        e.c0  = a;
        e.c1  = b;
        e.c2  = c;
        return e;
    endfunction

    function automatic entry_t one(input logic [7:0] a);
        return mk(2'd1, a, NUL_CHAR, NUL_CHAR);
    endfunction

    function automatic entry_t two(input logic [7:0] a, input logic [7:0] b);
        return mk(2'd2, a, b, NUL_CHAR);
    endfunction

    // Empty run: hard and soft signs.
    function automatic entry_t none();
        return mk(2'd0, NUL_CHAR, NUL_CHAR, NUL_CHAR);
    endfunction

    // Partner byte of a 0xD0 lead.
    function automatic entry_t map_d0(input logic [7:0] b);
        entry_t e;
        case (b)
            8'h81: e = two("Y", "o");
            8'h90: e = one("A");
            8'h91: e = one("B");
            8'h92: e = one("V");
            8'h93: e = one("G");
            8'h94: e = one("D");
            8'h95: e = one("E");
            8'h96: e = two("Z", "h");
            8'h97: e = one("Z");
            8'h98: e = one("I");
            8'h99: e = one("Y");
            8'h9A: e = one("K");
            8'h9B: e = one("L");
            8'h9C: e = one("M");
            8'h9D: e = one("N");
            8'h9E: e = one("O");
            8'h9F: e = one("P");
            8'hA0: e = one("R");
            8'hA1: e = one("S");
            8'hA2: e = one("T");
            8'hA3: e = one("U");
            8'hA4: e = one("F");
            8'hA5: e = two("K", "h");
            8'hA6: e = two("T", "s");
            8'hA7: e = two("C", "h");
            8'hA8: e = two("S", "h");
            8'hA9: e = mk(2'd3, "S", "c", "h");
            8'hAA: e = none();
            8'hAB: e = one("Y");
            8'hAC: e = none();
            8'hAD: e = one("E");
            8'hAE: e = two("Y", "u");
            8'hAF: e = two("Y", "a");
            8'hB0: e = one("a");
            8'hB1: e = one("b");
            8'hB2: e = one("v");
            8'hB3: e = one("g");
            8'hB4: e = one("d");
            8'hB5: e = one("e");
            8'hB6: e = two("z", "h");
            8'hB7: e = one("z");
            8'hB8: e = one("i");
            8'hB9: e = one("y");
            8'hBA: e = one("k");
            8'hBB: e = one("l");
            8'hBC: e = one("m");
            8'hBD: e = one("n");
            8'hBE: e = one("o");
            8'hBF: e = one("p");
            default: e = one(NO_MAP_CHAR);
        endcase
        return e;
    endfunction

    // Partner byte of a 0xD1 lead.
    function automatic entry_t map_d1(input logic [7:0] b);
        entry_t e;
        case (b)
            8'h80: e = one("r");
            8'h81: e = one("s");
            8'h82: e = one("t");
            8'h83: e = one("u");
            8'h84: e = one("f");
            8'h85: e = two("k", "h");
            8'h86: e = two("t", "s");
            8'h87: e = two("c", "h");
            8'h88: e = two("s", "h");
            8'h89: e = mk(2'd3, "s", "c", "h");
            8'h8A: e = none();
            8'h8B: e = one("y");
            8'h8C: e = none();
            8'h8D: e = one("e");
            8'h8E: e = two("y", "u");
            8'h8F: e = two("y", "a");
            8'h91: e = two("y", "o");
            default: e = one(NO_MAP_CHAR);
        endcase
        return e;
    endfunction

endpackage

FILE: hdl/utf8ct_in_if.sv
`timescale 1ns / 1ps

interface utf8ct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

FILE: hdl/utf8ct_out_if.sv
`timescale 1ns / 1ps

interface utf8ct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;

    modport source (output valid, output out_char, output run_last, input ready);
    modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

FILE: hdl/utf8ct_front.sv
`timescale 1ns / 1ps

module utf8ct_front (
    input  logic               clk,
    input  logic               rst_n,
    utf8ct_in_if.sink          in_item,
    input  logic               q_full,
    output utf8ct_pkg::push_t  push
);

    typedef enum logic [2:0] {
        LEAD_NONE = 3'b001,
        LEAD_D0   = 3'b010,
        LEAD_D1   = 3'b100
    } lead_t;

    lead_t lead_reg;
    lead_t lead_next;
    logic  take;

    assign in_item.ready = !q_full;
    assign take          = in_item.valid && !q_full;

    always_comb
    begin
        lead_next = lead_reg;
        push.push = 1'b0;
        push.data = utf8ct_pkg::one(in_item.in_byte);
        if (take)
        begin
            case (lead_reg)
                LEAD_D0:
                begin
                    lead_next = LEAD_NONE;
                    push.data = utf8ct_pkg::map_d0(in_item.in_byte);
                    push.push = (push.data.len != 2'd0);
                end
                LEAD_D1:
                begin
                    lead_next = LEAD_NONE;
                    push.data = utf8ct_pkg::map_d1(in_item.in_byte);
                    push.push = (push.data.len != 2'd0);
                end
                default:
                begin
                    lead_next = LEAD_NONE;
                    if (in_item.in_byte == utf8ct_pkg::LEAD_D0_BYTE ||
                        in_item.in_byte == utf8ct_pkg::LEAD_D1_BYTE)
                    begin
                        if (in_item.end_of_text)
                        begin
                            // lead with nothing after it
                            push.push = 1'b1;
                            push.data = utf8ct_pkg::one(utf8ct_pkg::NO_MAP_CHAR);
                        end
                        else if (in_item.in_byte == utf8ct_pkg::LEAD_D0_BYTE)
                        begin
                            lead_next = LEAD_D0;
                        end
                        else
                        begin
                            lead_next = LEAD_D1;
                        end
                    end
                    else
                    begin
                        push.push = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= LEAD_NONE;
        end
        else
        begin
            lead_reg <= lead_next;
        end
    end

endmodule

FILE: hdl/utf8ct_queue.sv
`timescale 1ns / 1ps

module utf8ct_queue #(
    parameter int Depth = utf8ct_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  utf8ct_pkg::push_t  push,
    input  logic               pop,
    output logic               full,
    output utf8ct_pkg::head_t  head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    utf8ct_pkg::entry_t mem_reg [Depth];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg,  count_next;
    logic               do_pop;

    assign full       = (count_reg == FullCnt);
    assign head.avail = (count_reg != '0);
    assign head.head  = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head.avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

FILE: hdl/utf8ct_back.sv
`timescale 1ns / 1ps

module utf8ct_back (
    input  logic               clk,
    input  logic               rst_n,
    input  utf8ct_pkg::head_t  q,
    output logic               pop,
    utf8ct_out_if.source       out_item
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       load;
    logic       is_last;
    logic [7:0] cur_char;

    assign out_item.valid    = valid_reg;
    assign out_item.out_char = char_reg;
    assign out_item.run_last = last_reg;

    assign load    = q.avail && (!valid_reg || out_item.ready);
    assign is_last = (idx_reg == (q.head.len - 2'd1));
    assign pop     = load && is_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_char = q.head.c0;
            2'd1:    cur_char = q.head.c1;
            default: cur_char = q.head.c2;
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            char_next  = cur_char;
            last_next  = is_last;
            idx_next   = is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_item.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

FILE: hdl/utf8_cyrillic_translit_core.sv
// A byte's characters pass through the run queue and then the output register.
// Throughput: one byte per cycle at the input while the run queue is not full, and
// one character per cycle at the output while the output is not stalled; while a
// byte that expands to n characters goes out, the run queue (QueueDepth runs) lets input keep flowing.
// Reset (rst_n low, asynchronous): clears the pending lead, the queue and output valid.
`timescale 1ns / 1ps

module utf8_cyrillic_translit_core #(
    parameter int QueueDepth = utf8ct_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    utf8ct_in_if.sink     in_item,
    utf8ct_out_if.source  out_item
);

    utf8ct_pkg::push_t push;
    utf8ct_pkg::head_t head;
    logic              q_full;
    logic              pop;

    utf8ct_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .q_full  (q_full),
        .push    (push)
    );

    utf8ct_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    utf8ct_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q        (head),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

FILE: hdl/utf8ct_checker.sv
`timescale 1ns / 1ps

module utf8ct_props (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       run_last
);

    // output register is cleared by reset
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // only table runs span several characters, and those are plain ASCII
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |-> !out_char[7])
        else $error("non-ASCII character inside a multi-character run");

    // rest of a run is already queued, so the output never gaps mid-run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |=> out_valid)
        else $error("gap inside a run");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(run_last))
        else $error("stalled item changed");

endmodule

bind utf8_cyrillic_translit_core utf8ct_props u_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .out_char  (out_item.out_char),
    .run_last  (out_item.run_last)
);
